### hdl/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// Shared widths, codes and the job record passed from the front end to the
// color back end of the thermal palette core.
// ----------------------------------------------------------------------------
`default_nettype none

package trp_pkg;

  // sample and window width, two's complement
  localparam int TEMP_W  = 16;
  // unsigned window span and clamped offset into it
  localparam int RANGE_W = TEMP_W;
  // normalized fraction, 0..65536 where 65536 is one
  localparam int FRAC_W  = 17;
  // rainbow / magma palette index
  localparam int IDX_W   = 8;
  // 255 * diff
  localparam int XD_W    = RANGE_W + IDX_W;
  // squared inverted fraction, up to 2^32
  localparam int SQ_W    = 2 * FRAC_W - 1;
  // packed rgb565 pixel
  localparam int PIX_W   = 16;

  localparam logic [FRAC_W-1:0] ONE_FIX  = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] HALF_FIX = FRAC_W'(32768);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int PAL_W      = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = TEMP_W;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PALETTE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LOW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_HIGH = 2'd2;

  // palette codes
  localparam logic [PAL_W-1:0] PAL_HEAT      = 3'd0;
  localparam logic [PAL_W-1:0] PAL_GRAY      = 3'd1;
  localparam logic [PAL_W-1:0] PAL_INV_GRAY  = 3'd2;
  localparam logic [PAL_W-1:0] PAL_INV_SQ    = 3'd3;
  localparam logic [PAL_W-1:0] PAL_RAINBOW   = 3'd4;
  localparam logic [PAL_W-1:0] PAL_MAGMA     = 3'd5;

  localparam logic [PAL_W-1:0]   PALETTE_RST = PAL_HEAT;
  localparam logic [TEMP_W-1:0]  WIN_LOW_RST  = TEMP_W'(320);
  localparam logic [TEMP_W-1:0]  WIN_HIGH_RST = TEMP_W'(640);

  // one classified sample on its way to the divider
  typedef struct packed {
    logic [PAL_W-1:0]   palette;
    logic [RANGE_W-1:0] range;
    logic [RANGE_W-1:0] diff;
    logic [XD_W-1:0]    xd;
  } job_t;

endpackage

`default_nettype wire

### hdl/temperature_to_rgb565_palette_core.sv
// ----------------------------------------------------------------------------
// temperature_to_rgb565_palette_core
// Thermal color map: clamps a temperature sample to a window, normalizes it
// and returns one RGB565 pixel from one of six palettes.
// ----------------------------------------------------------------------------
// channel   direction  beat contents
// s_*       in         tdata[15:0] temperature, signed, 1/16 degree
// m_*       out        tdata[15:0] pixel, r 15..11, g 10..5, b 4..0
// cfg_*     in         addr 0 palette, 1 window_low, 2 window_high
//
// one pixel per cycle sustained while m_tready stays high; registers from
// input beat to output beat: front register, queue slot, 17 divider stages
// (one quotient bit each), square stage and output register.
// rst is synchronous and clears all valid flags and loads register defaults.
// a stalled output freezes the back end; the 4-entry queue keeps s_tready
// high until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_to_rgb565_palette_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [trp_pkg::TEMP_W-1:0]      s_tdata,   // [15:0] temperature
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [trp_pkg::PIX_W-1:0]            m_tdata,   // [15:0] pixel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [trp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [trp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic          f_valid, f_ready;
  trp_pkg::job_t f_job;
  logic          q_valid, q_ready;
  trp_pkg::job_t q_job;

  trp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  trp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  trp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_job    (q_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

### hdl/trp_front.sv
// ----------------------------------------------------------------------------
// trp_front
// Holds the configuration registers, clamps each sample to the window and
// forms the window span and offset for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [trp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [trp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [trp_pkg::TEMP_W-1:0]       s_tdata,
  output logic                                  job_valid,
  input  wire logic                             job_ready,
  output trp_pkg::job_t                         job
);

  logic [trp_pkg::PAL_W-1:0]  palette;
  logic [trp_pkg::TEMP_W-1:0] win_low;
  logic [trp_pkg::TEMP_W-1:0] win_high;

  logic signed [trp_pkg::TEMP_W-1:0] lo_s, hi_s, t_s, tc_a, tc_b;
  logic                              empty;
  logic [trp_pkg::TEMP_W:0]          diff_w, range_w;
  logic [trp_pkg::RANGE_W-1:0]       diff_c, range_c;
  trp_pkg::job_t                     job_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !job_valid || job_ready;

  always_comb begin
    lo_s  = $signed(win_low);
    hi_s  = $signed(win_high);
    t_s   = $signed(s_tdata);
    tc_a  = (t_s < lo_s) ? lo_s : t_s;
    tc_b  = (tc_a > hi_s) ? hi_s : tc_a;
    empty = !(hi_s > lo_s);
    diff_w  = {tc_b[trp_pkg::TEMP_W-1], tc_b} - {lo_s[trp_pkg::TEMP_W-1], lo_s};
    range_w = {hi_s[trp_pkg::TEMP_W-1], hi_s} - {lo_s[trp_pkg::TEMP_W-1], lo_s};
    // an empty window divides zero by one, so both fraction and index are zero
    diff_c  = empty ? '0 : diff_w[trp_pkg::RANGE_W-1:0];
    range_c = empty ? trp_pkg::RANGE_W'(1) : range_w[trp_pkg::RANGE_W-1:0];
    job_next.palette = palette;
    job_next.range   = range_c;
    job_next.diff    = diff_c;
    job_next.xd      = {diff_c, trp_pkg::IDX_W'(0)} - {trp_pkg::IDX_W'(0), diff_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette   <= trp_pkg::PALETTE_RST;
      win_low   <= trp_pkg::WIN_LOW_RST;
      win_high  <= trp_pkg::WIN_HIGH_RST;
      job_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          trp_pkg::CFG_PALETTE:     palette  <= cfg_data[trp_pkg::PAL_W-1:0];
          trp_pkg::CFG_WINDOW_LOW:  win_low  <= cfg_data[trp_pkg::TEMP_W-1:0];
          trp_pkg::CFG_WINDOW_HIGH: win_high <= cfg_data[trp_pkg::TEMP_W-1:0];
          default: ;
        endcase
      end
      if (s_tready) begin
        job_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

### hdl/trp_queue.sv
// ----------------------------------------------------------------------------
// trp_queue
// Short job queue that lets the front end and the color back end stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire trp_pkg::job_t in_job,
  output logic       out_valid,
  input  wire logic  out_ready,
  output trp_pkg::job_t out_job
);

  trp_pkg::job_t               mem [trp_pkg::QUEUE_DEPTH];
  logic [trp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [trp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [trp_pkg::QPTR_W:0]    count;
  logic                        push, pop;

  assign in_ready  = count != (trp_pkg::QPTR_W + 1)'(trp_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (trp_pkg::QPTR_W + 1)'(trp_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

`default_nettype wire

### hdl/trp_back.sv
// ----------------------------------------------------------------------------
// trp_back
// Pipelined restoring divider for the fraction and the palette index, one
// quotient bit per stage, followed by the squaring stage, the palette lookup
// and the output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire trp_pkg::job_t               q_job,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [trp_pkg::PIX_W-1:0]        m_tdata
);

  localparam int NSTEP = trp_pkg::FRAC_W;

  typedef struct packed {
    logic                           v;
    logic [trp_pkg::PAL_W-1:0]      pal;
    logic [trp_pkg::RANGE_W-1:0]    range;
    logic [trp_pkg::RANGE_W-1:0]    rem_n;
    logic [trp_pkg::FRAC_W-1:0]     q_n;
    logic [trp_pkg::RANGE_W-1:0]    rem_x;
    logic [trp_pkg::IDX_W-1:0]      xlo;
    logic [trp_pkg::IDX_W-1:0]      q_x;
  } stage_t;

  typedef struct packed {
    logic                           v;
    logic [trp_pkg::PAL_W-1:0]      pal;
    logic [trp_pkg::FRAC_W-1:0]     n;
    logic [trp_pkg::IDX_W-1:0]      x;
    logic [trp_pkg::SQ_W-1:0]       sq;
  } post_t;

  stage_t st      [NSTEP];
  stage_t st_next [NSTEP];
  post_t  post, post_next;
  logic   adv;
  logic [trp_pkg::PIX_W-1:0] pix;

  // floor(v*31/65536) and floor(v*63/65536)
  function automatic logic [4:0] hi31(input logic [trp_pkg::FRAC_W-1:0] v);
    logic [trp_pkg::FRAC_W+4:0] p;
    p = {v, 5'b0} - {5'b0, v};
    return p[20:16];
  endfunction

  function automatic logic [5:0] hi63(input logic [trp_pkg::FRAC_W-1:0] v);
    logic [trp_pkg::FRAC_W+5:0] p;
    p = {v, 6'b0} - {6'b0, v};
    return p[21:16];
  endfunction

  function automatic logic [trp_pkg::PIX_W-1:0] pack565(input logic [4:0] r,
                                                        input logic [5:0] g,
                                                        input logic [4:0] b);
    return {r, g, b};
  endfunction

  // whole pipeline moves when the output slot is free or being taken
  assign adv     = !m_tvalid || m_tready;
  assign q_ready = adv;

  always_comb begin
    stage_t                   cur;
    logic                     nb, xb;
    logic [trp_pkg::RANGE_W:0] r2, rx;
    for (int k = 0; k < NSTEP; k++) begin
      if (k == 0) begin
        cur.v     = q_valid;
        cur.pal   = q_job.palette;
        cur.range = q_job.range;
        cur.rem_n = {1'b0, q_job.diff[trp_pkg::RANGE_W-1:1]};
        cur.q_n   = '0;
        cur.rem_x = q_job.xd[trp_pkg::XD_W-1:trp_pkg::IDX_W];
        cur.xlo   = q_job.xd[trp_pkg::IDX_W-1:0];
        cur.q_x   = '0;
        nb        = q_job.diff[0];
      end else begin
        cur = st[k-1];
        nb  = 1'b0;
      end
      r2 = {cur.rem_n, nb};
      if (r2 >= {1'b0, cur.range}) begin
        cur.rem_n = trp_pkg::RANGE_W'(r2 - {1'b0, cur.range});
        cur.q_n   = {cur.q_n[trp_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        cur.rem_n = r2[trp_pkg::RANGE_W-1:0];
        cur.q_n   = {cur.q_n[trp_pkg::FRAC_W-2:0], 1'b0};
      end
      // index quotient takes only the first eight stages
      if (k < trp_pkg::IDX_W) begin
        xb      = cur.xlo[trp_pkg::IDX_W-1];
        cur.xlo = {cur.xlo[trp_pkg::IDX_W-2:0], 1'b0};
        rx      = {cur.rem_x, xb};
        if (rx >= {1'b0, cur.range}) begin
          cur.rem_x = trp_pkg::RANGE_W'(rx - {1'b0, cur.range});
          cur.q_x   = {cur.q_x[trp_pkg::IDX_W-2:0], 1'b1};
        end else begin
          cur.rem_x = rx[trp_pkg::RANGE_W-1:0];
          cur.q_x   = {cur.q_x[trp_pkg::IDX_W-2:0], 1'b0};
        end
      end
      st_next[k] = cur;
    end
  end

  always_comb begin
    logic [trp_pkg::FRAC_W-1:0]   inv;
    logic [2*trp_pkg::FRAC_W-1:0] prod;
    inv            = trp_pkg::ONE_FIX - st[NSTEP-1].q_n;
    prod           = (2*trp_pkg::FRAC_W)'(inv) * (2*trp_pkg::FRAC_W)'(inv);
    post_next.v    = st[NSTEP-1].v;
    post_next.pal  = st[NSTEP-1].pal;
    post_next.n    = st[NSTEP-1].q_n;
    post_next.x    = st[NSTEP-1].q_x;
    post_next.sq   = prod[trp_pkg::SQ_W-1:0];
  end

  always_comb begin
    logic [trp_pkg::FRAC_W-1:0] tt, inv;
    logic [trp_pkg::SQ_W+4:0]   s31;
    logic [trp_pkg::SQ_W+5:0]   s63;
    logic [5:0]                 xs;
    inv = trp_pkg::ONE_FIX - post.n;
    s31 = {post.sq, 5'b0} - {5'b0, post.sq};
    s63 = {post.sq, 6'b0} - {6'b0, post.sq};
    xs  = post.x[5:0];
    tt  = '0;
    case (post.pal)
      trp_pkg::PAL_HEAT: begin
        if (post.n < trp_pkg::HALF_FIX) begin
          tt  = {post.n[trp_pkg::FRAC_W-2:0], 1'b0};
          pix = pack565(5'd0, hi63(tt), hi31(trp_pkg::ONE_FIX - tt));
        end else begin
          tt  = trp_pkg::FRAC_W'((post.n - trp_pkg::HALF_FIX) << 1);
          pix = pack565(hi31(tt), hi63(trp_pkg::ONE_FIX - tt), 5'd0);
        end
      end
      trp_pkg::PAL_GRAY: begin
        pix = pack565(hi31(post.n), hi63(post.n), hi31(post.n));
      end
      trp_pkg::PAL_INV_GRAY: begin
        pix = pack565(hi31(inv), hi63(inv), hi31(inv));
      end
      trp_pkg::PAL_INV_SQ: begin
        pix = pack565(s31[36:32], s63[37:32], s31[36:32]);
      end
      trp_pkg::PAL_RAINBOW: begin
        case (post.x[7:6])
          2'd0:    pix = pack565(5'd0, xs, 5'd31);
          2'd1:    pix = pack565(5'd0, 6'd63, 5'd31 - xs[5:1]);
          2'd2:    pix = pack565(xs[5:1], 6'd63, 5'd0);
          default: pix = pack565(5'd31, 6'd63 - xs, 5'd0);
        endcase
      end
      trp_pkg::PAL_MAGMA: begin
        case (post.x[7:6])
          2'd0:    pix = pack565({2'b0, xs[5:3]}, 6'd0, {1'b0, xs[5:2]});
          2'd1:    pix = pack565(5'd8 + {1'b0, xs[5:2]}, 6'd0, 5'd16 - {2'b0, xs[5:3]});
          2'd2:    pix = pack565(5'd24 + {3'b0, xs[5:4]}, {1'b0, xs[5:1]}, 5'd0);
          default: pix = pack565(5'd31, 6'd30 + {2'b0, xs[5:2]}, {3'b0, xs[5:4]});
        endcase
      end
      default: begin
        pix = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTEP; k++) begin
        st[k].v <= 1'b0;
      end
      post.v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < NSTEP; k++) begin
        st[k] <= st_next[k];
      end
      post     <= post_next;
      m_tvalid <= post.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= pix;
    end
  end

  a_bubble_in: assert property (@(posedge clk) disable iff (rst)
    adv && !q_valid |=> !st[0].v)
    else $error("divider stage filled without a job");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    post.v |-> post.n <= trp_pkg::ONE_FIX)
    else $error("fraction above one");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && st[NSTEP-1].v |=> post.v)
    else $error("job lost leaving the divider");

endmodule

`default_nettype wire
